[src/laq_pkg.sv]
// Shared types and constants of the linear array queue.
// Depends on nothing; every other file but laq_if and laq_ram imports it.
package laq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;

    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [FILL_W-1:0]       t_fill;
    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_SHOW = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_OVF   = 3'd1,
        ST_DEQ   = 3'd2,
        ST_UNF   = 3'd3,
        ST_SHOW  = 3'd4,
        ST_EMPTY = 3'd5
    } t_status;

    // Work for the back end: a status-only result, a slot write,
    // a single slot read, or a scan over a run of slots.
    typedef enum logic [1:0] {
        K_NOTE  = 2'd0,
        K_WRITE = 2'd1,
        K_READ  = 2'd2,
        K_SCAN  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_status status;
        t_addr   addr;
        t_addr   end_addr;
        t_val    value;
    } t_op;

endpackage

[src/laq_if.sv]
// Handshake channels of the linear array queue: command in, result out.
// Depends on nothing; plain valid/ready with the payload fields.
interface laq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface laq_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] value_res;
    logic               last;

    modport source (output valid, output status, output value_res, output last, input ready);
    modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

[src/linear_array_queue.sv]
// Top level of the linear array queue: front end, work queue, back end.
// Depends on laq_pkg, laq_if, laq_front, laq_fifo and laq_back.
//
// Usage
//   i_in carries one command per transfer: enqueue, dequeue or display
//   (code 3 is taken and dropped without a result). o_out carries the
//   results: status, value and a last flag on the final result of a
//   command. The queue is linear: slots are not reused until it drains.
// Pipeline and throughput
//   A result comes from its command through the work queue and then the
//   result register: the front end classifies into the two-entry work
//   queue, the back end executes into the result register. Enqueue,
//   dequeue and status-only results go out at one per cycle while
//   o_out.ready stays high. Display of n held elements gives n results,
//   one read each of the single slot RAM read port; meanwhile the work queue fills and i_in.ready drops.
// Reset
//   i_rst_n is synchronous, active low: both positions return to zero,
//   the work queue and the result register empty. Slot contents are not
//   cleared; only written slots are ever read.
// Stalls
//   While a result waits on a low o_out.ready it holds and execution halts; the
//   front end keeps taking commands until the work queue is full.
module linear_array_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    laq_in_if.sink    i_in,
    laq_out_if.source o_out
);
    import laq_pkg::*;

    logic push_valid;
    logic push_ready;
    t_op  push_op;
    logic pop;
    logic head_valid;
    t_op  head_op;

    // Classify commands and advance the positions at transfer time.
    laq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_op    (push_op)
    );

    // Hold classified work so either side can stall alone.
    laq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_op    (head_op)
    );

    // Execute work against the slot RAM and drive the results.
    laq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_op    (head_op),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

[src/laq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read data holds while no read is issued.
module laq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/laq_front.sv]
// Front end: accepts commands, keeps head and fill positions, classifies.
// Depends on laq_pkg and laq_in_if; pushes t_op work into the queue.
module laq_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    laq_in_if.sink       i_in,
    input  logic         i_push_ready,
    output logic         o_push_valid,
    output laq_pkg::t_op o_push_op
);
    import laq_pkg::*;

    t_addr r_head, n_head;
    t_fill r_fill, n_fill;
    t_fill head_ext;
    logic  empty;
    logic  accept;
    t_op   op;
    logic  op_vld;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid & i_push_ready;
    assign head_ext   = t_fill'(r_head);
    assign empty      = head_ext >= r_fill;

    always_comb begin
        n_head       = r_head;
        n_fill       = r_fill;
        op_vld       = 1'b1;
        op.kind      = K_NOTE;
        op.status    = ST_ENQ;
        op.addr      = r_head;
        op.end_addr  = r_head;
        op.value     = i_in.value;
        unique case (t_cmd'(i_in.command))
            CMD_ENQ: begin
                if (r_fill == t_fill'(DEPTH)) begin
                    op.status = ST_OVF;
                end else begin
                    op.kind   = K_WRITE;
                    op.addr   = t_addr'(r_fill);
                    n_fill    = r_fill + t_fill'(1);
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    op.status = ST_UNF;
                end else begin
                    op.kind   = K_READ;
                    op.status = ST_DEQ;
                    // taking the last element rewinds both positions
                    if (head_ext + t_fill'(1) >= r_fill) begin
                        n_head = '0;
                        n_fill = '0;
                    end else begin
                        n_head = r_head + t_addr'(1);
                    end
                end
            end
            CMD_SHOW: begin
                if (empty) begin
                    op.status = ST_EMPTY;
                end else begin
                    op.kind     = K_SCAN;
                    op.status   = ST_SHOW;
                    op.end_addr = t_addr'(r_fill - t_fill'(1));
                end
            end
            CMD_NONE: begin
                op_vld = 1'b0;
            end
        endcase
    end

    assign o_push_valid = accept & op_vld;
    assign o_push_op    = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (accept) begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

`ifndef SYNTHESIS
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (t_fill'(r_head) < r_fill) || (r_head == '0 && r_fill == '0))
        else $error("head position not below fill position");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_fill'(DEPTH))
        else $error("fill position beyond depth");
`endif

endmodule

[src/laq_fifo.sv]
// Two-entry queue of t_op work between the front and back ends.
// Depends on laq_pkg.
module laq_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  laq_pkg::t_op i_push_op,
    output logic         o_push_ready,
    input  logic         i_pop,
    output logic         o_head_valid,
    output laq_pkg::t_op o_head_op
);
    import laq_pkg::*;

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_push_ready = r_cnt != 2'd2;
    assign o_head_valid = r_cnt != 2'd0;
    assign o_head_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_op;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");
`endif

endmodule

[src/laq_back.sv]
// Back end: carries out queued work against the slot RAM, drives results.
// Depends on laq_pkg, laq_out_if and laq_ram.
module laq_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_head_valid,
    input  laq_pkg::t_op i_head_op,
    output logic         o_pop,
    laq_out_if.source    o_out
);
    import laq_pkg::*;

    logic    r_scan_on, n_scan_on;
    t_addr   r_idx, n_idx;
    logic    r_out_vld;
    t_status r_out_status;
    t_val    r_out_val;
    logic    r_out_last;
    logic    r_out_ram;

    logic       free;
    logic       issue;
    t_addr      cur;
    logic       ram_we;
    logic       ram_re;
    t_addr      ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    t_val       s_val;
    logic       s_last;
    logic       s_ram;

    assign free  = ~r_out_vld | o_out.ready;
    assign issue = i_head_valid & free;
    assign cur   = r_scan_on ? r_idx : i_head_op.addr;

    always_comb begin
        n_scan_on = r_scan_on;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = i_head_op.addr;
        s_val     = '0;
        s_last    = 1'b1;
        s_ram     = 1'b0;
        if (issue) begin
            unique case (i_head_op.kind)
                K_NOTE: begin
                    o_pop = 1'b1;
                end
                K_WRITE: begin
                    ram_we = 1'b1;
                    s_val  = i_head_op.value;
                    o_pop  = 1'b1;
                end
                K_READ: begin
                    ram_re = 1'b1;
                    s_ram  = 1'b1;
                    o_pop  = 1'b1;
                end
                K_SCAN: begin
                    ram_re    = 1'b1;
                    ram_raddr = cur;
                    s_ram     = 1'b1;
                    s_last    = cur == i_head_op.end_addr;
                    // hold the op until its final slot is read
                    if (s_last) begin
                        o_pop     = 1'b1;
                        n_scan_on = 1'b0;
                    end else begin
                        n_scan_on = 1'b1;
                        n_idx     = cur + t_addr'(1);
                    end
                end
            endcase
        end
    end

    laq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_head_op.addr),
        .i_wdata (i_head_op.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_scan_on <= n_scan_on;
            if (issue) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (issue) begin
            r_out_status <= i_head_op.status;
            r_out_val    <= s_val;
            r_out_last   <= s_last;
            r_out_ram    <= s_ram;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.status    = r_out_status;
    assign o_out.value_res = r_out_ram ? t_val'(ram_rdata) : r_out_val;
    assign o_out.last      = r_out_last;

`ifndef SYNTHESIS
    a_scan_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_on |-> (i_head_valid && i_head_op.kind == K_SCAN))
        else $error("scan in progress without a scan op at the queue head");
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> free)
        else $error("op retired while the result register is blocked");
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("slot RAM written and read in one cycle");
`endif

endmodule

[sim/laq_checker.sv]
// Checker of the linear array queue: watches both channels, predicts the results.
// Depends on laq_pkg and laq_if; instantiated by tb beside the block.
module laq_checker
    import laq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    laq_in_if    i_cmd_ch,
    laq_out_if   i_res_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        t_status status;
        t_val    value;
        logic    last;
    } t_queue_result;

    // Own copy of the queue: slot store, head slot and fill count.
    t_val          slot_data [DEPTH];
    t_addr         head_slot;
    t_fill         fill_count;
    t_queue_result awaited_results [$];

    task automatic await_result(input t_status status, input t_val value, input logic last);
        t_queue_result res;
        res.status = status;
        res.value  = value;
        res.last   = last;
        awaited_results.push_back(res);
    endtask

    // Apply one command to the copy and queue the results it causes.
    task automatic predict_queue_op(input t_cmd cmd, input t_val value);
        t_fill slot;
        t_fill next_head;
        case (cmd)
            CMD_ENQ: begin
                if (fill_count >= DEPTH) begin
                    await_result(ST_OVF, '0, 1'b1);
                end else begin
                    slot_data[fill_count] = value;
                    fill_count = fill_count + 1'b1;
                    await_result(ST_ENQ, value, 1'b1);
                end
            end
            CMD_DEQ: begin
                if (t_fill'(head_slot) >= fill_count) begin
                    await_result(ST_UNF, '0, 1'b1);
                end else begin
                    await_result(ST_DEQ, slot_data[head_slot], 1'b1);
                    // widen before the step so that slot 63 does not wrap
                    next_head = t_fill'(head_slot) + 1'b1;
                    if (next_head >= fill_count) begin
                        head_slot  = '0;
                        fill_count = '0;
                    end else begin
                        head_slot = t_addr'(next_head);
                    end
                end
            end
            CMD_SHOW: begin
                if (t_fill'(head_slot) >= fill_count) begin
                    await_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (slot = t_fill'(head_slot); slot < fill_count; slot = slot + 1'b1) begin
                        await_result(ST_SHOW, slot_data[slot], (slot + 1 >= fill_count));
                    end
                end
            end
            default: begin
                // unused code: dropped, no result
            end
        endcase
    endtask

    task automatic check_result();
        t_queue_result want;
        if (awaited_results.size() == 0) begin
            o_fail_count = o_fail_count + 1;
            $display("%0t: mismatch: expected no result, got status %0d value %0d last %0d",
                     $time, i_res_ch.status, i_res_ch.value_res, i_res_ch.last);
        end else begin
            want = awaited_results.pop_front();
            if (i_res_ch.status !== want.status || i_res_ch.value_res !== want.value ||
                i_res_ch.last !== want.last) begin
                o_fail_count = o_fail_count + 1;
                $display("%0t: mismatch: expected status %0d value %0d last %0d,",
                         $time, want.status, want.value, want.last,
                         " got status %0d value %0d last %0d",
                         i_res_ch.status, i_res_ch.value_res, i_res_ch.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot    = '0;
            fill_count   = '0;
            o_fail_count = 0;
            awaited_results.delete();
        end else begin
            // a result never stems from a command taken at the same edge
            if (i_cmd_ch.valid && i_cmd_ch.ready) begin
                predict_queue_op(t_cmd'(i_cmd_ch.command), i_cmd_ch.value);
            end
            if (i_res_ch.valid && i_res_ch.ready) begin
                check_result();
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[sim/tb.sv]
// Testbench top of the linear array queue: clock, reset, stimulus and verdict.
// Depends on laq_pkg, laq_if, linear_array_queue and laq_checker.
module tb;
    import laq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Percentage of cycles in which each side holds off.
    int send_gap_pct = 6;
    int recv_gap_pct = 58;

    int fail_count;
    int pending_count;

    laq_in_if  cmd_ch ();
    laq_out_if res_ch ();

    linear_array_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    laq_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ch     (cmd_ch),
        .i_res_ch     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest correct run, even with every
    // display emitting a full queue under the heaviest receiver stall.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Receiver: drop ready at random, changed on the falling edge only.
    always @(negedge i_clk) begin
        res_ch.ready = ($urandom_range(99) >= recv_gap_pct);
    end

    // Mostly full-range random values, now and then an extreme.
    function automatic t_val pick_value();
        t_val v;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // Start and end on a falling edge. Valid stays high after the transfer
    // so that back-to-back commands leave no gap unless one is drawn.
    task automatic send_command(input t_cmd cmd, input t_val value);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   = 1'b1;
        cmd_ch.command = cmd;
        cmd_ch.value   = value;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every awaited result has arrived.
    task automatic hold_until_drained();
        cmd_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // A run of commands with a given bias; the rest goes to display and
    // a rare unused code.
    task automatic run_segment(input int count, input int enq_pct, input int deq_pct);
        int   k;
        int   roll;
        t_cmd cmd;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < enq_pct) begin
                cmd = CMD_ENQ;
            end else if (roll < enq_pct + deq_pct) begin
                cmd = CMD_DEQ;
            end else if (roll < 98) begin
                cmd = CMD_SHOW;
            end else begin
                cmd = CMD_NONE;
            end
            send_command(cmd, pick_value());
        end
    endtask

    // Alternate filling, draining and mixed runs so that the queue both
    // grows deep and drains back to empty, resetting its positions.
    task automatic run_random_phase(input int count);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            len = $urandom_range(4, 20);
            if (len > left) begin
                len = left;
            end
            case ($urandom_range(2))
                0:       run_segment(len, 80, 10);
                1:       run_segment(len, 12, 78);
                default: run_segment(len, 45, 37);
            endcase
            left -= len;
        end
    endtask

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_ENQ;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty display, underflow, the unused code, extreme
        // values, a full display, draining to empty and a single-element queue.
        send_command(CMD_SHOW, '0);
        send_command(CMD_DEQ, '1);
        send_command(CMD_NONE, 32'hffff_ffff);
        send_command(CMD_ENQ, 32'h8000_0000);
        send_command(CMD_ENQ, 32'h7fff_ffff);
        send_command(CMD_ENQ, '0);
        send_command(CMD_ENQ, '1);
        send_command(CMD_ENQ, 32'h5555_5555);
        send_command(CMD_ENQ, 32'haaaa_aaaa);
        send_command(CMD_SHOW, 32'h5555_5555);
        send_command(CMD_NONE, '0);
        send_command(CMD_DEQ, 32'haaaa_aaaa);
        send_command(CMD_DEQ, '0);
        send_command(CMD_SHOW, '1);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '0);
        send_command(CMD_SHOW, '0);
        send_command(CMD_ENQ, pick_value());
        send_command(CMD_SHOW, '0);
        send_command(CMD_DEQ, '0);

        // Sender mostly busy, receiver stalling often.
        run_random_phase(20);
        hold_until_drained();

        // Sender idling often, receiver mostly ready.
        send_gap_pct = 58;
        recv_gap_pct = 6;
        run_random_phase(20);
        hold_until_drained();

        // No idling: fill past the depth to reach overflow and full-length
        // displays, then follow with a run biased to dequeues.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_segment(80, 95, 2);
        run_segment(30, 15, 75);

        hold_until_drained();
        // allow for any stray result a faulty block might still emit
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
